/* src/mwo_pkg.sv */
// ----------------------------------------------------------------------------
// mwo_pkg - shared types and constants for the multiphase oscillator
// Widths, tap phase offsets, waveform codes, sine-table fill states and the
// write-port bundle between the table filler and the sine RAM.
// ----------------------------------------------------------------------------
`default_nettype none

package mwo_pkg;

    // Phase accumulator and sine table geometry
    localparam int PHASE_BITS           = 32;
    localparam int SINE_TABLE_ADDR_BITS = 10;
    localparam int TAP_COUNT            = 16;
    localparam int TAP_W                = $clog2(TAP_COUNT);
    localparam int TURN_W               = 32;
    localparam int QTR_SIZE             = 1 << SINE_TABLE_ADDR_BITS;
    localparam int SINE_DEPTH           = QTR_SIZE + 1;
    localparam int SINE_IDX_W           = SINE_TABLE_ADDR_BITS + 1;

    // Sample format
    localparam int SAMPLE_W     = 16;
    localparam int SAMPLE_MAG_W = 15;
    localparam int FULL_SCALE   = 32767;

    // Taylor series used to fill the quarter-wave table
    localparam int              TAYLOR_TERMS = 8;
    localparam int              TERM_W       = 33;
    localparam int              SUM_W        = 34;
    localparam int              ANGLE_W      = 31;
    localparam int              DIVISOR_W    = 9;
    localparam logic [ANGLE_W-1:0] HALF_PI_Q30 = 31'd1686629713;

    typedef enum logic [2:0] {
        WAVE_SINE     = 2'd0,
        WAVE_TRIANGLE = 2'd1,
        WAVE_SAW      = 2'd2,
        WAVE_SQUARE   = 2'd3
    } wave_sel_t;

    typedef enum logic [2:0] {
        FILL_ANGLE,
        FILL_MUL1,
        FILL_MUL2,
        FILL_RECIP,
        FILL_FIX,
        FILL_ACC,
        FILL_WRITE,
        FILL_DONE
    } fill_state_t;

    typedef struct packed {
        logic                    en;
        logic [SINE_IDX_W-1:0]   addr;
        logic [SAMPLE_MAG_W-1:0] data;
    } table_wr_t;

    // Offset of m fifteen-degree steps, rounded to the accumulator grid
    function automatic logic [PHASE_BITS-1:0] tap_offset(input int m);
        logic [63:0] num;
        num = (64'(m) << PHASE_BITS) + 64'd12;
        return PHASE_BITS'(num / 64'd24);
    endfunction

    // Lower half: taps 0..7; upper half: the same plus 180 degrees (saw only)
    localparam logic [PHASE_BITS-1:0] TAP_OFFSET [TAP_COUNT] = '{
        tap_offset(0),  tap_offset(2),  tap_offset(3),  tap_offset(4),
        tap_offset(6),  tap_offset(8),  tap_offset(9),  tap_offset(10),
        tap_offset(12), tap_offset(14), tap_offset(15), tap_offset(16),
        tap_offset(18), tap_offset(20), tap_offset(21), tap_offset(22)
    };

    // Bring an accumulator phase to a 32-bit fraction of a turn
    function automatic logic [TURN_W-1:0] to_turn(input logic [PHASE_BITS-1:0] p);
        logic [63:0] p64;
        p64 = 64'(p);
        return (PHASE_BITS >= TURN_W) ? TURN_W'(p64 >> (PHASE_BITS - TURN_W))
                                      : TURN_W'(p64 << (TURN_W - PHASE_BITS));
    endfunction

    // Divisor (2n)(2n+1) of the n-th Taylor term
    function automatic logic [DIVISOR_W-1:0] term_divisor(input logic [3:0] n);
        logic [DIVISOR_W-1:0] d;
        unique case (n)
            4'd1:    d = 9'd6;
            4'd2:    d = 9'd20;
            4'd3:    d = 9'd42;
            4'd4:    d = 9'd72;
            4'd5:    d = 9'd110;
            4'd6:    d = 9'd156;
            4'd7:    d = 9'd210;
            default: d = 9'd272;
        endcase
        return d;
    endfunction

    // Reciprocal floor(2^32 / divisor) of the n-th term; with a dividend
    // below 2^32 the scaled product falls at most one short of the quotient
    function automatic logic [ANGLE_W-1:0] term_recip(input logic [3:0] n);
        logic [ANGLE_W-1:0] r;
        unique case (n)
            4'd1:    r = 31'd715827882;
            4'd2:    r = 31'd214748364;
            4'd3:    r = 31'd102261126;
            4'd4:    r = 31'd59652323;
            4'd5:    r = 31'd39045157;
            4'd6:    r = 31'd27531841;
            4'd7:    r = 31'd20452225;
            default: r = 31'd15790320;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/multiphase_waveform_oscillator_top.sv */
// ----------------------------------------------------------------------------
// multiphase_waveform_oscillator_top - sixteen-tap phase-offset oscillator
// An accepted tick passes the pending beat, tap, phase and output registers;
// taps leave one per cycle while tap_stall is low, through the single tap
// pipeline (offset add, sine RAM read, waveform shaping). Reset: phase and
// wave select clear; the sine table is then built for all 1025 entries,
// during which step_stall stays high.
// ----------------------------------------------------------------------------
`default_nettype none

module multiphase_waveform_oscillator_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write_en,
    input  wire logic [1:0]                    cfg_write_data,
    input  wire logic                          step_valid,
    output logic                               step_stall,
    input  wire logic [31:0]                   phase_step,
    output logic                               tap_valid,
    input  wire logic                          tap_stall,
    output logic [3:0]                         tap_index,
    output logic signed [mwo_pkg::SAMPLE_W-1:0] wave_sample,
    output logic                               last_tap
);

    localparam int PB = mwo_pkg::PHASE_BITS;
    localparam int TW = mwo_pkg::TAP_W;
    localparam int AB = mwo_pkg::SINE_TABLE_ADDR_BITS;

    mwo_pkg::wave_sel_t wave_sel_reg;

    logic [PB-1:0] acc_reg, acc_next;
    logic          pend_valid_reg;
    logic [PB-1:0] pend_phase_reg;
    logic          act_valid_reg;
    logic [PB-1:0] act_phase_reg;
    logic [TW-1:0] act_tap_reg;
    logic          b_valid_reg;
    logic [mwo_pkg::TURN_W-1:0] b_u_reg;
    logic [TW-1:0] b_tap_reg;
    logic          b_neg_reg;
    logic          out_valid_reg;
    logic [TW-1:0] out_tap_reg;
    logic signed [mwo_pkg::SAMPLE_W-1:0] out_sample_reg;
    logic          out_last_reg;

    mwo_pkg::table_wr_t table_wr;
    logic               table_done;

    logic          step_accept;
    logic          adv;
    logic          a_fire;
    logic          act_last;
    logic          act_load;
    logic          is_saw;
    logic [TW-1:0] off_idx;
    logic [PB-1:0] tap_phase;
    logic [mwo_pkg::TURN_W-1:0] a_u;
    logic          a_neg;
    logic [AB-1:0] sine_frac;
    logic [mwo_pkg::SINE_IDX_W-1:0] sine_addr;
    logic [mwo_pkg::SAMPLE_MAG_W-1:0] sine_mag;

    logic signed [33:0] lin_x;
    logic [31:0]        lin_mag;
    logic               lin_saw;
    logic [mwo_pkg::SAMPLE_MAG_W-1:0] mag;
    logic               mag_neg;
    logic signed [mwo_pkg::SAMPLE_W-1:0] base_sample;
    logic signed [mwo_pkg::SAMPLE_W-1:0] final_sample;

    // Scale a triangle or saw magnitude to full scale with rounding
    function automatic logic [mwo_pkg::SAMPLE_MAG_W-1:0] scale_mag(
        input logic [31:0] m,
        input logic        saw
    );
        logic [47:0] prod;
        logic [47:0] res;
        prod = (48'(m) << 15) - 48'(m);
        res  = saw ? ((prod + (48'd1 << 30)) >> 31) : ((prod + (48'd1 << 29)) >> 30);
        return res[mwo_pkg::SAMPLE_MAG_W-1:0];
    endfunction

    // Negate, saturating the most negative code
    function automatic logic signed [mwo_pkg::SAMPLE_W-1:0] neg_sat(
        input logic signed [mwo_pkg::SAMPLE_W-1:0] v
    );
        return (v == -16'sd32768) ? 16'sd32767 : -v;
    endfunction

    // Table builder and quarter-wave sine RAM
    mwo_sine_fill u_sine_fill (
        .clk        (clk),
        .rst_n      (rst_n),
        .table_wr   (table_wr),
        .table_done (table_done)
    );

    mwo_ram #(
        .WIDTH (mwo_pkg::SAMPLE_MAG_W),
        .DEPTH (mwo_pkg::SINE_DEPTH)
    ) u_sine_ram (
        .clk     (clk),
        .wr_en   (table_wr.en),
        .wr_addr (table_wr.addr),
        .wr_data (table_wr.data),
        .rd_en   (adv),
        .rd_addr (sine_addr),
        .rd_data (sine_mag)
    );

    // Handshake and pipeline advance
    assign step_stall  = !table_done || pend_valid_reg;
    assign step_accept = step_valid && !step_stall;
    assign adv         = !out_valid_reg || !tap_stall;
    assign a_fire      = adv && act_valid_reg;
    assign act_last    = (act_tap_reg == TW'(mwo_pkg::TAP_COUNT - 1));
    assign act_load    = pend_valid_reg && (!act_valid_reg || (a_fire && act_last));
    assign acc_next    = acc_reg + PB'(phase_step);

    // Tap phase: lower-half offset, or the 180 degree set for saw
    assign is_saw    = (wave_sel_reg == mwo_pkg::WAVE_SAW);
    assign off_idx   = is_saw ? act_tap_reg : {1'b0, act_tap_reg[TW-2:0]};
    assign tap_phase = act_phase_reg + mwo_pkg::TAP_OFFSET[off_idx];
    assign a_u       = mwo_pkg::to_turn(tap_phase);
    assign a_neg     = act_tap_reg[TW-1] && !is_saw;

    // Mirror the table index in the second and fourth quadrants
    assign sine_frac = a_u[29 -: AB];
    assign sine_addr = a_u[30] ? (mwo_pkg::SINE_IDX_W'(mwo_pkg::QTR_SIZE) - {1'b0, sine_frac})
                               : {1'b0, sine_frac};

    // Shape the waveform from the registered phase
    always_comb
    begin
        lin_x   = '0;
        lin_saw = 1'b0;
        mag     = '0;
        mag_neg = 1'b0;
        if (wave_sel_reg == mwo_pkg::WAVE_SAW)
        begin
            lin_saw = 1'b1;
            lin_x   = b_u_reg[31] ? $signed({2'b00, b_u_reg}) - 34'sh1_0000_0000
                                  : $signed({2'b00, b_u_reg});
        end
        else if (b_u_reg < 32'h4000_0000)
        begin
            lin_x = $signed({2'b00, b_u_reg});
        end
        else if (b_u_reg < 32'hC000_0000)
        begin
            lin_x = 34'sh0_8000_0000 - $signed({2'b00, b_u_reg});
        end
        else
        begin
            lin_x = $signed({2'b00, b_u_reg}) - 34'sh1_0000_0000;
        end
        lin_mag = lin_x[33] ? 32'(-lin_x) : 32'(lin_x);

        unique case (wave_sel_reg)
            mwo_pkg::WAVE_SINE:
            begin
                mag     = sine_mag;
                mag_neg = b_u_reg[31];
            end
            mwo_pkg::WAVE_TRIANGLE, mwo_pkg::WAVE_SAW:
            begin
                mag     = scale_mag(lin_mag, lin_saw);
                mag_neg = lin_x[33];
            end
            mwo_pkg::WAVE_SQUARE:
            begin
                mag     = mwo_pkg::SAMPLE_MAG_W'(mwo_pkg::FULL_SCALE);
                mag_neg = b_u_reg[31];
            end
            default:
            begin
                mag     = '0;
                mag_neg = 1'b0;
            end
        endcase

        base_sample  = mag_neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        final_sample = b_neg_reg ? neg_sat(base_sample) : base_sample;
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_sel_reg <= mwo_pkg::WAVE_SINE;
        end
        else if (cfg_write_en)
        begin
            wave_sel_reg <= mwo_pkg::wave_sel_t'(cfg_write_data);
        end
    end

    // Advance the accumulator and hold the accepted beat until the taps are free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end
        else if (step_accept)
        begin
            acc_reg        <= acc_next;
            pend_valid_reg <= 1'b1;
        end
        else if (act_load)
        begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_accept)
        begin
            pend_phase_reg <= acc_next;
        end
    end

    // Step through the sixteen taps of the active tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_valid_reg <= 1'b0;
            act_tap_reg   <= '0;
        end
        else if (act_load)
        begin
            act_valid_reg <= 1'b1;
            act_tap_reg   <= '0;
        end
        else if (a_fire)
        begin
            if (act_last)
            begin
                act_valid_reg <= 1'b0;
            end
            act_tap_reg <= act_tap_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (act_load)
        begin
            act_phase_reg <= pend_phase_reg;
        end
    end

    // Phase stage, aligned with the sine RAM read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg <= act_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_u_reg   <= a_u;
            b_tap_reg <= act_tap_reg;
            b_neg_reg <= a_neg;
        end
    end

    // Output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_tap_reg    <= b_tap_reg;
            out_sample_reg <= final_sample;
            out_last_reg   <= (b_tap_reg == TW'(mwo_pkg::TAP_COUNT - 1));
        end
    end

    assign tap_valid   = out_valid_reg;
    assign tap_index   = out_tap_reg;
    assign wave_sample = out_sample_reg;
    assign last_tap    = out_last_reg;

`ifndef SYNTH
    // A waiting beat moves into an idle tap stage at the next edge
    assert property (@(posedge clk) disable iff (!rst_n)
        (pend_valid_reg && !act_valid_reg) |=> act_valid_reg)
        else $error("waiting beat not loaded into idle tap stage");

    // No taps leave before the sine table is complete
    assert property (@(posedge clk) disable iff (!rst_n)
        !table_done |-> !tap_valid)
        else $error("tap beat before sine table fill finished");

    // The last flag marks tap fifteen and nothing else
    assert property (@(posedge clk) disable iff (!rst_n)
        tap_valid |-> (last_tap == (tap_index == 4'(mwo_pkg::TAP_COUNT - 1))))
        else $error("last_tap does not match tap_index");

    // Square wave only takes the two full-scale levels
    assert property (@(posedge clk) disable iff (!rst_n)
        (tap_valid && (wave_sel_reg == mwo_pkg::WAVE_SQUARE)) |->
        ((wave_sample == 16'sd32767) || (wave_sample == -16'sd32767)))
        else $error("square tap off the full-scale levels");
`endif

endmodule

`default_nettype wire

/* src/mwo_ram.sv */
// ----------------------------------------------------------------------------
// mwo_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; the read data holds while the
// read enable is low.
// ----------------------------------------------------------------------------
`default_nettype none

module mwo_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* src/mwo_sine_fill.sv */
// ----------------------------------------------------------------------------
// mwo_sine_fill - quarter-wave sine table builder
// After reset, evaluates a nine-term Taylor series in Q30 for each table entry
// with one shared multiplier, dividing each term by a reciprocal multiply and
// one correction step, then writes the rounded sample to the sine RAM. Raises
// done once the last entry is written.
// ----------------------------------------------------------------------------
`default_nettype none

module mwo_sine_fill (
    input  wire logic           clk,
    input  wire logic           rst_n,
    output mwo_pkg::table_wr_t  table_wr,
    output logic                table_done
);

    mwo_pkg::fill_state_t state_reg, state_next;

    logic [mwo_pkg::SINE_IDX_W-1:0] k_reg, k_next;
    logic [3:0]                     n_reg, n_next;
    logic [mwo_pkg::ANGLE_W-1:0]    x_reg, x_next;
    logic [mwo_pkg::TERM_W-1:0]     term_reg, term_next;
    logic [mwo_pkg::TERM_W-1:0]     prod_reg, prod_next;
    logic [mwo_pkg::TERM_W-1:0]     quo_reg, quo_next;
    logic signed [mwo_pkg::SUM_W-1:0] sum_reg, sum_next;

    logic [mwo_pkg::TERM_W-1:0]    mul_a;
    logic [mwo_pkg::ANGLE_W-1:0]   mul_b;
    logic [63:0]                   mul_p;
    logic [mwo_pkg::TERM_W-1:0]    fix_rem;
    logic                          fix_up;
    logic [mwo_pkg::SUM_W-2:0]     sum_pos;
    logic [47:0]                   scaled;
    logic [17:0]                   rounded;
    logic [mwo_pkg::SAMPLE_MAG_W-1:0] entry;

    // Select multiplier operands: angle scaling, two powers of x, then the
    // reciprocal and the back-multiply of the division
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            mwo_pkg::FILL_ANGLE:
            begin
                mul_a = mwo_pkg::TERM_W'(k_reg);
                mul_b = mwo_pkg::HALF_PI_Q30;
            end
            mwo_pkg::FILL_MUL1:
            begin
                mul_a = term_reg;
                mul_b = x_reg;
            end
            mwo_pkg::FILL_MUL2:
            begin
                mul_a = prod_reg;
                mul_b = x_reg;
            end
            mwo_pkg::FILL_RECIP:
            begin
                mul_a = quo_reg;
                mul_b = mwo_pkg::term_recip(n_reg);
            end
            mwo_pkg::FILL_FIX:
            begin
                mul_a = prod_reg;
                mul_b = mwo_pkg::ANGLE_W'(mwo_pkg::term_divisor(n_reg));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // Remainder of the estimated quotient; bump it when a divisor still fits
    assign fix_rem = quo_reg - mwo_pkg::TERM_W'(mul_p);
    assign fix_up  = (fix_rem >= mwo_pkg::TERM_W'(mwo_pkg::term_divisor(n_reg)));

    // Round the Q30 sum to a sample, clamped to 0..full scale
    assign sum_pos = sum_reg[mwo_pkg::SUM_W-1] ? '0 : sum_reg[mwo_pkg::SUM_W-2:0];
    assign scaled  = (48'(sum_pos) << 15) - 48'(sum_pos) + (48'd1 << 29);
    assign rounded = 18'(scaled >> 30);
    assign entry   = (rounded > 18'(mwo_pkg::FULL_SCALE))
                     ? mwo_pkg::SAMPLE_MAG_W'(mwo_pkg::FULL_SCALE)
                     : rounded[mwo_pkg::SAMPLE_MAG_W-1:0];

    // Next state and datapath
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        x_next     = x_reg;
        term_next  = term_reg;
        prod_next  = prod_reg;
        quo_next   = quo_reg;
        sum_next   = sum_reg;
        table_wr   = '0;
        table_done = 1'b0;
        unique case (state_reg)
            mwo_pkg::FILL_ANGLE:
            begin
                x_next     = mwo_pkg::ANGLE_W'((mul_p + 64'(mwo_pkg::QTR_SIZE >> 1))
                                               >> mwo_pkg::SINE_TABLE_ADDR_BITS);
                term_next  = mwo_pkg::TERM_W'(x_next);
                sum_next   = mwo_pkg::SUM_W'(x_next);
                n_next     = 4'd1;
                state_next = mwo_pkg::FILL_MUL1;
            end
            mwo_pkg::FILL_MUL1:
            begin
                prod_next  = mwo_pkg::TERM_W'(mul_p >> 30);
                state_next = mwo_pkg::FILL_MUL2;
            end
            mwo_pkg::FILL_MUL2:
            begin
                quo_next   = mwo_pkg::TERM_W'(mul_p >> 30);
                state_next = mwo_pkg::FILL_RECIP;
            end
            mwo_pkg::FILL_RECIP:
            begin
                // Estimate, at most one short of the true quotient
                prod_next  = mwo_pkg::TERM_W'(mul_p >> 32);
                state_next = mwo_pkg::FILL_FIX;
            end
            mwo_pkg::FILL_FIX:
            begin
                quo_next   = prod_reg + mwo_pkg::TERM_W'(fix_up);
                state_next = mwo_pkg::FILL_ACC;
            end
            mwo_pkg::FILL_ACC:
            begin
                term_next = quo_reg;
                sum_next  = n_reg[0] ? sum_reg - $signed({1'b0, quo_reg})
                                     : sum_reg + $signed({1'b0, quo_reg});
                if (n_reg == 4'(mwo_pkg::TAYLOR_TERMS))
                begin
                    state_next = mwo_pkg::FILL_WRITE;
                end
                else
                begin
                    n_next     = n_reg + 1'b1;
                    state_next = mwo_pkg::FILL_MUL1;
                end
            end
            mwo_pkg::FILL_WRITE:
            begin
                table_wr.en   = 1'b1;
                table_wr.addr = k_reg;
                table_wr.data = entry;
                if (k_reg == mwo_pkg::SINE_IDX_W'(mwo_pkg::QTR_SIZE))
                begin
                    state_next = mwo_pkg::FILL_DONE;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = mwo_pkg::FILL_ANGLE;
                end
            end
            mwo_pkg::FILL_DONE:
            begin
                table_done = 1'b1;
            end
            default:
            begin
                state_next = mwo_pkg::FILL_ANGLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mwo_pkg::FILL_ANGLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequencing counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= '0;
            n_reg <= '0;
        end
        else
        begin
            k_reg <= k_next;
            n_reg <= n_next;
        end
    end

    // Arithmetic registers
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        term_reg <= term_next;
        prod_reg <= prod_next;
        quo_reg  <= quo_next;
        sum_reg  <= sum_next;
    end

endmodule

`default_nettype wire
